FILE: sv/wra_pkg.sv
// Shared types and constants of the windowed rate accumulator.
// No dependencies; used by the accumulator core.
package wra_pkg;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TIME_W-1:0] ACC_MAX = {TIME_W{1'b1}};

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

  // Input word actions
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic               action;
    logic [COUNT_W-1:0] batch_count;
    logic [TIME_W-1:0]  batch_start;
    logic [TIME_W-1:0]  now_time;
  } in_word_t;

  typedef struct packed {
    logic              accepted;
    logic [TIME_W-1:0] total_items;
    logic [TIME_W-1:0] total_time;
    logic [TIME_W-1:0] rate_q16;
  } out_word_t;

endpackage

FILE: sv/wra_stream_if.sv
// Valid/ready channel carrying one word of a given type.
// Depends on nothing; the word type comes in as a parameter.
interface wra_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

FILE: sv/windowed_rate_accumulator_core.sv
// Windowed rate accumulator: one add or clear word in, one totals word out.
// A clear, or a batch reported before the window or past its end, goes straight to the rate
// division; a batch inside it is accumulated first, and an early batch is scaled before that.
// The shared 65-bit adder/subtractor does the work: 32 shift-add steps, 80 restoring division
// steps for the scaling and 64 for the rate. The next word is accepted the cycle after the result is taken.
// Reset (async, active low) clears the totals, the add history and both registers.
module windowed_rate_accumulator_core #(
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wra_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wra_pkg::TIME_W-1:0]        cfg_wdata_i,
  wra_stream_if.sink                        in_i,
  wra_stream_if.source                      out_o
);

  localparam int unsigned TW = wra_pkg::TIME_W;
  localparam int unsigned CW = wra_pkg::COUNT_W;
  localparam int unsigned TB = (TIME_BITS < TW) ? TIME_BITS : TW;
  localparam int unsigned CB = (COUNT_BITS < CW) ? COUNT_BITS : CW;
  localparam logic [TW-1:0] TIME_MASK  = {TW{1'b1}} >> (TW - TB);
  localparam logic [CW-1:0] COUNT_MASK = {CW{1'b1}} >> (CW - CB);
  localparam int unsigned PW  = TW + CW;   // product / dividend width
  localparam int unsigned QW  = 64;        // quotient width
  localparam int unsigned AW  = QW + 1;    // shared adder operand width
  localparam int unsigned ITW = 7;
  localparam logic [ITW-1:0] MUL_STEPS  = ITW'(CW);
  localparam logic [ITW-1:0] SDIV_STEPS = ITW'(PW);
  localparam logic [ITW-1:0] RDIV_STEPS = ITW'(TW + 16);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MSUB, S_DSUB, S_MUL, S_DIV, S_ROUND, S_INC,
    S_WCHK, S_FIRST, S_INTV, S_ACC1, S_ACC2, S_RSET, S_OUT
  } state_e;

  state_e          state_q, state_d;
  logic [TW-1:0]   win_start_q, win_start_d, win_len_q, win_len_d;
  logic            action_q, action_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [TW-1:0]   start_q, start_d, now_q, now_d;
  logic [TW-1:0]   item_total_q, item_total_d, time_total_q, time_total_d;
  logic [TW-1:0]   earliest_q, earliest_d, latest_q, latest_d;
  logic            have_adds_q, have_adds_d;
  logic [TW-1:0]   mcand_q, mcand_d, divisor_q, divisor_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [TW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [ITW-1:0]  iter_q, iter_d;
  logic            rnd_q, rnd_d;
  logic            rate_mode_q, rate_mode_d;
  logic [TW-1:0]   term1_q, term1_d, term2_q, term2_d, interval_q, interval_d;
  logic            accepted_q, accepted_d;
  logic [TW-1:0]   rate_q, rate_d;

  // Shared adder/subtractor
  logic [AW-1:0]   alu_a, alu_b;
  logic            alu_sub;
  logic [AW:0]     alu_sum;
  logic            alu_carry;

  logic [TW-1:0]   ws_m, wl_m, sel_t, win_off;
  logic [TW:0]     rem_sh, sum_a, sum_b;
  logic            before_e;

  assign ws_m = win_start_q & TIME_MASK;
  assign wl_m = win_len_q & TIME_MASK;

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
  assign alu_carry = alu_sum[AW];

  assign rem_sh   = {rem_q, prod_q[PW-1]};
  assign before_e = start_q < earliest_q;
  assign sel_t    = (before_e || (start_q <= latest_q)) ? latest_q : start_q;
  assign win_off  = start_q - ws_m;
  assign sum_a    = {1'b0, term1_q} + {1'b0, term2_q};
  assign sum_b    = {1'b0, item_total_q} + {1'b0, TW'(cnt_q)};

  assign in_i.ready              = (state_q == S_IDLE);
  assign out_o.valid             = (state_q == S_OUT);
  assign out_o.word.accepted     = accepted_q;
  assign out_o.word.total_items  = item_total_q;
  assign out_o.word.total_time   = time_total_q;
  assign out_o.word.rate_q16     = rate_q;

  always_comb begin
    state_d      = state_q;
    win_start_d  = win_start_q;
    win_len_d    = win_len_q;
    action_d     = action_q;
    cnt_d        = cnt_q;
    start_d      = start_q;
    now_d        = now_q;
    item_total_d = item_total_q;
    time_total_d = time_total_q;
    earliest_d   = earliest_q;
    latest_d     = latest_q;
    have_adds_d  = have_adds_q;
    mcand_d      = mcand_q;
    divisor_d    = divisor_q;
    prod_d       = prod_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    iter_d       = iter_q;
    rnd_d        = rnd_q;
    rate_mode_d  = rate_mode_q;
    term1_d      = term1_q;
    term2_d      = term2_q;
    interval_d   = interval_q;
    accepted_d   = accepted_q;
    rate_d       = rate_q;
    alu_a        = '0;
    alu_b        = '0;
    alu_sub      = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        wra_pkg::CFG_WINDOW_START:  win_start_d = cfg_wdata_i;
        wra_pkg::CFG_WINDOW_LENGTH: win_len_d   = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          action_d   = in_i.word.action;
          cnt_d      = in_i.word.batch_count & COUNT_MASK;
          start_d    = in_i.word.batch_start & TIME_MASK;
          now_d      = in_i.word.now_time & TIME_MASK;
          accepted_d = 1'b0;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (action_q == wra_pkg::ACT_CLEAR) begin
          item_total_d = '0;
          time_total_d = '0;
          earliest_d   = '0;
          latest_d     = '0;
          have_adds_d  = 1'b0;
          state_d      = S_RSET;
        end else if (now_q < ws_m) begin
          state_d = S_RSET;
        end else if (start_q < ws_m) begin
          state_d = S_MSUB;
        end else begin
          state_d = S_WCHK;
        end
      end
      S_MSUB: begin
        alu_a   = AW'(now_q);
        alu_b   = AW'(ws_m);
        alu_sub = 1'b1;
        mcand_d = alu_sum[TW-1:0];
        state_d = S_DSUB;
      end
      S_DSUB: begin
        alu_a     = AW'(now_q);
        alu_b     = AW'(start_q);
        alu_sub   = 1'b1;
        divisor_d = alu_sum[TW-1:0];
        prod_d    = {{TW{1'b0}}, cnt_q};
        iter_d    = MUL_STEPS;
        state_d   = S_MUL;
      end
      S_MUL: begin
        // add the multiplicand on a set low bit, then shift the product right
        alu_a  = AW'(prod_q[PW-1:CW]);
        alu_b  = prod_q[0] ? AW'(mcand_q) : '0;
        prod_d = {alu_sum[TW:0], prod_q[CW-1:1]};
        if (iter_q == ITW'(1)) begin
          rem_d       = '0;
          quo_d       = '0;
          iter_d      = SDIV_STEPS;
          rate_mode_d = 1'b0;
          state_d     = S_DIV;
        end else begin
          iter_d = iter_q - ITW'(1);
        end
      end
      S_DIV: begin
        alu_a   = AW'(rem_sh);
        alu_b   = AW'(divisor_q);
        alu_sub = 1'b1;
        rem_d   = alu_carry ? alu_sum[TW-1:0] : rem_sh[TW-1:0];
        quo_d   = {quo_q[QW-2:0], alu_carry};
        prod_d  = {prod_q[PW-2:0], 1'b0};
        if (iter_q == ITW'(1)) begin
          state_d = S_ROUND;
        end else begin
          iter_d = iter_q - ITW'(1);
        end
      end
      S_ROUND: begin
        // round half up: bump when twice the remainder reaches the divisor
        alu_a   = AW'({rem_q, 1'b0});
        alu_b   = AW'(divisor_q);
        alu_sub = 1'b1;
        rnd_d   = alu_carry;
        state_d = S_INC;
      end
      S_INC: begin
        alu_a = AW'(quo_q);
        alu_b = AW'(rnd_q);
        quo_d = alu_sum[QW-1:0];
        if (rate_mode_q) begin
          rate_d  = (alu_sum[QW-1:TW] != '0) ? wra_pkg::ACC_MAX : alu_sum[TW-1:0];
          state_d = S_OUT;
        end else begin
          cnt_d   = alu_sum[CW-1:0];
          start_d = ws_m;
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        if ((wl_m == '0) || (win_off < wl_m)) begin
          accepted_d = 1'b1;
          state_d    = S_FIRST;
        end else begin
          state_d = S_RSET;
        end
      end
      S_FIRST: begin
        if (!have_adds_q) begin
          earliest_d  = start_q;
          latest_d    = start_q;
          have_adds_d = 1'b1;
        end
        state_d = S_INTV;
      end
      S_INTV: begin
        // skip time already covered by earlier batches; clamp negative spans to zero
        term1_d = before_e ? (earliest_q - start_q) : '0;
        term2_d = (now_q > sel_t) ? (now_q - sel_t) : '0;
        if (before_e) begin
          earliest_d = start_q;
        end
        state_d = S_ACC1;
      end
      S_ACC1: begin
        interval_d   = sum_a[TW] ? wra_pkg::ACC_MAX : sum_a[TW-1:0];
        item_total_d = sum_b[TW] ? wra_pkg::ACC_MAX : sum_b[TW-1:0];
        state_d      = S_ACC2;
      end
      S_ACC2: begin
        alu_a        = AW'(time_total_q);
        alu_b        = AW'(interval_q);
        time_total_d = alu_sum[TW] ? wra_pkg::ACC_MAX : alu_sum[TW-1:0];
        latest_d     = now_q;
        state_d      = S_RSET;
      end
      S_RSET: begin
        // dividend is item_total shifted up by 16, left aligned
        prod_d      = {item_total_q, {CW{1'b0}}};
        divisor_d   = (time_total_q == '0) ? TW'(1) : time_total_q;
        rem_d       = '0;
        quo_d       = '0;
        iter_d      = RDIV_STEPS;
        rate_mode_d = 1'b1;
        state_d     = S_DIV;
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      win_start_q  <= '0;
      win_len_q    <= '0;
      action_q     <= 1'b0;
      cnt_q        <= '0;
      start_q      <= '0;
      now_q        <= '0;
      item_total_q <= '0;
      time_total_q <= '0;
      earliest_q   <= '0;
      latest_q     <= '0;
      have_adds_q  <= 1'b0;
      mcand_q      <= '0;
      divisor_q    <= '0;
      prod_q       <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      iter_q       <= '0;
      rnd_q        <= 1'b0;
      rate_mode_q  <= 1'b0;
      term1_q      <= '0;
      term2_q      <= '0;
      interval_q   <= '0;
      accepted_q   <= 1'b0;
      rate_q       <= '0;
    end else begin
      state_q      <= state_d;
      win_start_q  <= win_start_d;
      win_len_q    <= win_len_d;
      action_q     <= action_d;
      cnt_q        <= cnt_d;
      start_q      <= start_d;
      now_q        <= now_d;
      item_total_q <= item_total_d;
      time_total_q <= time_total_d;
      earliest_q   <= earliest_d;
      latest_q     <= latest_d;
      have_adds_q  <= have_adds_d;
      mcand_q      <= mcand_d;
      divisor_q    <= divisor_d;
      prod_q       <= prod_d;
      rem_q        <= rem_d;
      quo_q        <= quo_d;
      iter_q       <= iter_d;
      rnd_q        <= rnd_d;
      rate_mode_q  <= rate_mode_d;
      term1_q      <= term1_d;
      term2_q      <= term2_d;
      interval_q   <= interval_d;
      accepted_q   <= accepted_d;
      rate_q       <= rate_d;
    end
  end

endmodule
